FILE: hw/rtl/double_round_to_integral_assert.svh
// assertion macros for the rounding block
// no dependencies
`ifndef DOUBLE_ROUND_TO_INTEGRAL_ASSERT_SVH
`define DOUBLE_ROUND_TO_INTEGRAL_ASSERT_SVH
`define DRI_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define DRI_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: hw/rtl/dri_pkg.sv
// package for the rounding block: action codes and helper constants
// no dependencies
package dri_pkg;
  typedef enum logic [2:0] {
    ACT_TRUNC = 3'd0,
    ACT_FLOOR = 3'd1,
    ACT_CEIL  = 3'd2,
    ACT_ROUND = 3'd3,
    ACT_ABS   = 3'd4
  } action_t;
  localparam int EXP_W  = 11;
  localparam int FRAC_W = 52;
  localparam logic [10:0] EXP_BIAS = 11'd1023;
  localparam logic [10:0] EXP_BIG  = 11'd1075;
  localparam logic [10:0] EXP_ALL1 = 11'h7ff;
endpackage

FILE: hw/rtl/dri_if.sv
// valid/ready channel interface carrying a payload of parameter width
// depends on nothing
interface dri_if #(parameter int W = 64) (input logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/dri_core.sv
// combinational rounding of one double to an integral value, or its absolute value
// depends on dri_pkg
module dri_core import dri_pkg::*; (
  input  logic [2:0]  action,
  input  logic [63:0] operand_bits,
  output logic [63:0] result_bits
);
  logic        sgn;
  logic [10:0] ex;
  logic [51:0] fr;
  logic [52:0] mant;
  logic [5:0]  sh;
  logic [52:0] fmask;
  logic [52:0] ipart;
  logic [52:0] fpart;
  logic [52:0] half;
  logic        inexact;
  logic        up;
  logic [53:0] mag;
  logic        is_nan;
  logic        passthru;
  logic        lt_one;
  logic [10:0] e_out;
  logic [51:0] f_out;
  logic [63:0] rnd;

  assign sgn = operand_bits[63];
  assign ex  = operand_bits[62:52];
  assign fr  = operand_bits[51:0];
  assign is_nan = (ex == EXP_ALL1) && (fr != '0);
  assign passthru = (ex >= EXP_BIG);
  assign lt_one = (ex < EXP_BIAS);
  assign mant = {ex != '0, fr};

  // integer and fraction split of the significand
  always_comb begin
    sh = lt_one ? 6'd53 : 6'(EXP_BIG - ex);
    fmask = (sh >= 6'd53) ? {53{1'b1}} : ((53'd1 << sh) - 53'd1);
    half = (sh == 6'd0) ? '0 : ((sh >= 6'd54) ? '0 : (53'd1 << (sh - 6'd1)));
    if (sh == 6'd53) half = {1'b1, 52'd0};
    ipart = mant & ~fmask;
    fpart = mant & fmask;
    inexact = fpart != '0;
    if (lt_one) begin
      // value below one: half threshold means exponent exactly -1
      inexact = (ex != '0) || (fr != '0);
    end
    case (action)
      ACT_FLOOR: up = sgn && inexact;
      ACT_CEIL:  up = !sgn && inexact;
      ACT_ROUND: up = lt_one ? (ex == EXP_BIAS - 11'd1) : (fpart >= half && inexact);
      default:   up = 1'b0;
    endcase
  end

  // rebuild the double from the integer magnitude
  always_comb begin
    mag = lt_one ? 54'd0 : {1'b0, ipart};
    if (up) mag = lt_one ? 54'd1 : ({1'b0, ipart} + (54'd1 << sh));
    e_out = ex;
    f_out = '0;
    if (mag == '0) begin
      rnd = 64'd0;
    end else if (lt_one) begin
      rnd = {sgn, EXP_BIAS, 52'd0};
    end else if (mag[53]) begin
      rnd = {sgn, 11'(ex + 11'd1), 52'd0};
    end else begin
      f_out = mag[51:0];
      rnd = {sgn, e_out, f_out};
    end
  end

  always_comb begin
    if (is_nan) begin
      result_bits = operand_bits;
    end else begin
      case (action)
        ACT_TRUNC, ACT_FLOOR, ACT_CEIL, ACT_ROUND:
          result_bits = passthru ? operand_bits : rnd;
        ACT_ABS: result_bits = {1'b0, operand_bits[62:0]};
        default: result_bits = operand_bits;
      endcase
    end
  end
endmodule

FILE: hw/rtl/double_round_to_integral.sv
// top level of the double rounding block: input register, core, output register
// depends on dri_pkg, dri_if, dri_core and the assertion header
//
// channel  direction  payload
// in       sink       action[2:0], operand_bits[63:0]
// out      source     result_bits[63:0]
//
// one item per cycle while the output stage is empty or being taken; an item
// accepted on in is held in the input register and then the output register,
// where out valid is raised; the input and output registers form a two stage
// pipeline that advances whenever the output stage is empty or being taken
// reset (rst_n low, synchronous) empties both stages
`include "double_round_to_integral_assert.svh"
module double_round_to_integral import dri_pkg::*; (
  input logic clk,
  input logic rst_n,
  dri_if.sink   in_ch,
  dri_if.source out_ch
);
  logic        in_vld_r, out_vld_r;
  logic [2:0]  act_r;
  logic [63:0] opd_r;
  logic [63:0] res_r;
  logic [63:0] res_nxt;
  logic        adv;

  assign adv = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign out_ch.valid = out_vld_r;
  assign out_ch.data = res_r;

  dri_core u_core (.action(act_r), .operand_bits(opd_r), .result_bits(res_nxt));

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      in_vld_r <= in_ch.valid;
      out_vld_r <= in_vld_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      act_r <= in_ch.data[66:64];
      opd_r <= in_ch.data[63:0];
      res_r <= res_nxt;
    end
  end

  `DRI_ASSERT_NEXT(a_hold, clk, rst_n, out_vld_r && !out_ch.ready, out_vld_r && $stable(res_r))
  `DRI_ASSERT_NEXT(a_flow, clk, rst_n, adv && in_vld_r, out_vld_r)
endmodule
